// ===== rtl/core/pdcch_ss_pkg.sv =====
// Shared types, constants and lookup functions for the UE search space start block.
package pdcch_ss_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BANDWIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHICH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXT_CP    = 2'd2;

    localparam logic [1:0] BANDWIDTH_RESET = 2'd3;
    localparam logic [1:0] PHICH_RESET     = 2'd0;
    localparam logic       EXT_CP_RESET    = 1'b0;

    localparam int unsigned Y_W        = 17;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned REG_W      = 10;
    localparam int unsigned CCE_W      = 7;
    localparam int unsigned RECIP_W    = 13;
    localparam int unsigned BIT_CNT_W  = 5;

    localparam logic [15:0]        HASH_MULT  = 16'd39827;
    localparam logic [Y_W:0]       HASH_MOD   = 18'd65537;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
    localparam logic [BIT_CNT_W-1:0] DIV_LAST_BIT = 5'(Y_W - 1);

    typedef struct packed {
        logic [15:0] ue_identifier;
        logic [3:0]  subframe_number;
        logic [1:0]  aggregation_log2;
        logic [1:0]  control_symbols;
    } req_t;

    typedef struct packed {
        logic [6:0] cce_start;
        logic       start_valid;
        logic [6:0] cce_total;
    } res_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic mul;
        logic red;
        logic div_init;
        logic div_step;
    } cmd_t;

    function automatic logic [REG_W-1:0] reg_base(input logic [1:0] bw);
        logic [REG_W-1:0] v;
        unique case (bw)
            2'd0: v = 10'd12;
            2'd1: v = 10'd50;
            2'd2: v = 10'd100;
            default: v = 10'd200;
        endcase
        return v;
    endfunction

    function automatic logic [REG_W-1:0] reg_step(input logic [1:0] bw);
        logic [REG_W-1:0] v;
        unique case (bw)
            2'd0: v = 10'd18;
            2'd1: v = 10'd75;
            2'd2: v = 10'd150;
            default: v = 10'd300;
        endcase
        return v;
    endfunction

    // PHICH group count, ceil(Ng * 6 * RB / 48), before the extended prefix doubling.
    function automatic logic [4:0] phich_groups(input logic [1:0] bw, input logic [1:0] ng);
        logic [4:0] v;
        unique case ({bw, ng})
            4'b0000: v = 5'd1;
            4'b0001: v = 5'd1;
            4'b0010: v = 5'd1;
            4'b0011: v = 5'd2;
            4'b0100: v = 5'd1;
            4'b0101: v = 5'd2;
            4'b0110: v = 5'd4;
            4'b0111: v = 5'd7;
            4'b1000: v = 5'd2;
            4'b1001: v = 5'd4;
            4'b1010: v = 5'd7;
            4'b1011: v = 5'd13;
            4'b1100: v = 5'd3;
            4'b1101: v = 5'd7;
            4'b1110: v = 5'd13;
            default: v = 5'd25;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/pdcch_ss_ctrl.sv =====
// Sequencing state machine for the hash iterations and the remainder division.
module pdcch_ss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [3:0]            subframe_number,
    output logic                  busy,
    output logic                  done,
    output pdcch_ss_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_RED   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] iter_reg, iter_next;
    logic [pdcch_ss_pkg::BIT_CNT_W-1:0] bit_reg, bit_next;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    iter_next  = subframe_number;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.red = 1'b1;
                if (iter_reg == 4'd0)
                begin
                    state_next = S_DINIT;
                end
                else
                begin
                    iter_next  = iter_reg - 4'd1;
                    state_next = S_MUL;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                bit_next     = pdcch_ss_pkg::DIV_LAST_BIT;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            bit_reg   <= bit_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== rtl/core/pdcch_ss_dp.sv =====
// Datapath: configuration registers, CCE count, modular hash and remainder divider.
module pdcch_ss_dp (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_write,
    input  logic [pdcch_ss_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pdcch_ss_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  pdcch_ss_pkg::req_t                         request,
    input  pdcch_ss_pkg::cmd_t                         cmd,
    output pdcch_ss_pkg::res_t                         result
);

    localparam int unsigned YW = pdcch_ss_pkg::Y_W;
    localparam int unsigned RW = pdcch_ss_pkg::REG_W;
    localparam int unsigned CW = pdcch_ss_pkg::CCE_W;

    logic [1:0] bw_reg;
    logic [1:0] ng_reg;
    logic       ext_reg;

    logic [YW-1:0]                    y_reg;
    logic [1:0]                       agg_reg;
    logic [RW-1:0]                    quads_reg;
    logic [CW-1:0]                    ncce_reg;
    logic [CW-1:0]                    slots_reg;
    logic [CW-1:0]                    rem_reg;
    logic [pdcch_ss_pkg::PROD_W-1:0]  prod_reg;

    logic [RW-1:0] reg_base_val;
    logic [RW-1:0] reg_step_val;
    logic [RW-1:0] regs_total;
    logic [RW-1:0] overhead;
    logic [5:0]    groups;
    logic [RW+pdcch_ss_pkg::RECIP_W-1:0] recip_prod;
    logic [CW-1:0] ncce_next;
    logic [YW:0]   mod_diff;
    logic [YW-1:0] y_reduced;
    logic [CW:0]   rem_shift;
    logic [CW-1:0] rem_next;
    logic          slots_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg  <= pdcch_ss_pkg::BANDWIDTH_RESET;
            ng_reg  <= pdcch_ss_pkg::PHICH_RESET;
            ext_reg <= pdcch_ss_pkg::EXT_CP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pdcch_ss_pkg::CFG_BANDWIDTH:
                begin
                    bw_reg <= cfg_data[1:0];
                end
                pdcch_ss_pkg::CFG_PHICH:
                begin
                    ng_reg <= cfg_data[1:0];
                end
                pdcch_ss_pkg::CFG_EXT_CP:
                begin
                    ext_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        groups = ext_reg ? {pdcch_ss_pkg::phich_groups(bw_reg, ng_reg), 1'b0}
                         : {1'b0, pdcch_ss_pkg::phich_groups(bw_reg, ng_reg)};
        overhead = RW'(4) + RW'(groups) + {RW'(groups)} + RW'(groups);
        reg_base_val = pdcch_ss_pkg::reg_base(bw_reg);
        reg_step_val = pdcch_ss_pkg::reg_step(bw_reg);
        unique case (request.control_symbols)
            2'd2:    regs_total = reg_base_val + reg_step_val;
            2'd3:    regs_total = reg_base_val + {reg_step_val[RW-2:0], 1'b0};
            default: regs_total = reg_base_val;
        endcase
    end

    assign recip_prod = quads_reg * pdcch_ss_pkg::DIV9_RECIP;
    assign ncce_next  = recip_prod[16 +: CW];

    assign mod_diff  = {2'b00, prod_reg[15:0]} - {2'b00, prod_reg[31:16]};
    assign y_reduced = mod_diff[YW] ? YW'(mod_diff + pdcch_ss_pkg::HASH_MOD) : mod_diff[YW-1:0];

    assign rem_shift = {rem_reg, y_reg[YW-1]};
    assign rem_next  = (rem_shift >= {1'b0, slots_reg}) ? CW'(rem_shift - {1'b0, slots_reg})
                                                        : rem_shift[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y_reg   <= {1'b0, request.ue_identifier};
            agg_reg <= request.aggregation_log2;
            if (request.control_symbols != 2'd0 && regs_total >= overhead)
            begin
                quads_reg <= regs_total - overhead;
            end
            else
            begin
                quads_reg <= '0;
            end
        end
        if (cmd.calc)
        begin
            ncce_reg  <= ncce_next;
            slots_reg <= ncce_next >> agg_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= pdcch_ss_pkg::PROD_W'(y_reg)
                        * pdcch_ss_pkg::PROD_W'(pdcch_ss_pkg::HASH_MULT);
        end
        if (cmd.red)
        begin
            y_reg <= y_reduced;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            y_reg   <= {y_reg[YW-2:0], 1'b0};
        end
    end

    assign slots_zero         = (slots_reg == '0);
    assign result.cce_total   = ncce_reg;
    assign result.start_valid = !slots_zero;
    assign result.cce_start   = slots_zero ? '0 : CW'(rem_reg << agg_reg);

endmodule

// ===== rtl/core/pdcch_ue_search_space_cce_start_core.sv =====
// Top level of the LTE UE-specific search space first-CCE calculator.
//
// Channel   Direction  Handshake               Content
// request   in         start high, busy low    RNTI, subframe, aggregation, symbols
// result    out        done strobe, one cycle  first CCE, valid flag, CCE count
// cfg       in         cfg_valid and cfg_ready bandwidth, PHICH ratio, extended prefix
//
// A request runs from the accepting edge through a CCE count step, subframe_number + 1
// rounds of the modular hash, each a multiply step and a reduction step, a divider init
// step, and the remainder divider, which retires one dividend bit per cycle over 17 bits.
// Reset clears the controller and loads the configuration reset values.
// The block takes one request at a time and the result beat cannot be held off.
module pdcch_ue_search_space_cce_start_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  pdcch_ss_pkg::req_t                    request,
    output logic                                  done,
    output pdcch_ss_pkg::res_t                    result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pdcch_ss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pdcch_ss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    pdcch_ss_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    pdcch_ss_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .subframe_number (request.subframe_number),
        .busy            (busy),
        .done            (done),
        .cmd             (cmd)
    );

    pdcch_ss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd),
        .result    (result)
    );

endmodule

// ===== tb/pdcch_cce_start_checker.sv =====
`timescale 1ns / 100ps
// Checker for the search space core: predicts each result beat and compares it with the core.
module pdcch_cce_start_checker
    import pdcch_ss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  req_t                   request,
    input  logic                   done,
    input  res_t                   result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int unsigned RB_PER_BW [4]       = '{6, 25, 50, 100};
    localparam int unsigned REG_BASE_PER_BW [4] = '{12, 50, 100, 200};
    localparam int unsigned REG_STEP_PER_BW [4] = '{18, 75, 150, 300};
    localparam int unsigned PHICH_SIXTHS [4]    = '{1, 3, 6, 12};
    localparam longint unsigned Y_MULT = 39827;
    localparam longint unsigned Y_MOD  = 65537;
    localparam int PRINT_LIMIT = 100;

    logic [1:0] bw_sel;
    logic [1:0] ng_sel;
    logic       ext_cp;
    res_t       predicted_q [$];
    int         printed;

    function automatic int unsigned region_cces(input logic [1:0] syms);
        int unsigned prod;
        int unsigned groups;
        int unsigned regs;
        int unsigned overhead;
        prod = PHICH_SIXTHS[ng_sel] * RB_PER_BW[bw_sel];
        groups = (prod + 47) / 48;
        if (ext_cp)
        begin
            groups = groups * 2;
        end
        if (syms == 2'd0)
        begin
            return 0;
        end
        regs = REG_BASE_PER_BW[bw_sel] + (int'(syms) - 1) * REG_STEP_PER_BW[bw_sel];
        overhead = 4 + 3 * groups;
        if (regs < overhead)
        begin
            return 0;
        end
        return (regs - overhead) / 9;
    endfunction

    function automatic res_t predict_cce_start(input req_t item);
        res_t            p;
        longint unsigned y;
        int unsigned     ncce;
        int unsigned     slots;
        ncce = region_cces(item.control_symbols);
        slots = ncce >> item.aggregation_log2;
        y = item.ue_identifier;
        for (int i = 0; i <= int'(item.subframe_number); i++)
        begin
            y = (y * Y_MULT) % Y_MOD;
        end
        p.cce_total = 7'(ncce);
        if (slots == 0)
        begin
            p.cce_start = '0;
            p.start_valid = 1'b0;
        end
        else
        begin
            p.cce_start = 7'((y % slots) << item.aggregation_log2);
            p.start_valid = 1'b1;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (printed < PRINT_LIMIT)
        begin
            $display("[%0t] result beat error: %s", $realtime, what);
        end
        printed++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            bw_sel = BANDWIDTH_RESET;
            ng_sel = PHICH_RESET;
            ext_cp = EXT_CP_RESET;
            predicted_q.delete();
            mismatches = 0;
            printed = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BANDWIDTH: bw_sel = cfg_data[1:0];
                    CFG_PHICH:     ng_sel = cfg_data[1:0];
                    CFG_EXT_CP:    ext_cp = cfg_data[0];
                    default:       ;
                endcase
            end
            if (start && !busy)
            begin
                predicted_q.push_back(predict_cce_start(request));
            end
            if (done)
            begin
                if (predicted_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat start=%0d valid=%0d total=%0d",
                        result.cce_start, result.start_valid, result.cce_total));
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (result.cce_start !== want.cce_start)
                    begin
                        report_mismatch($sformatf("cce_start got %0d want %0d",
                            result.cce_start, want.cce_start));
                    end
                    if (result.start_valid !== want.start_valid)
                    begin
                        report_mismatch($sformatf("start_valid got %0d want %0d",
                            result.start_valid, want.start_valid));
                    end
                    if (result.cce_total !== want.cce_total)
                    begin
                        report_mismatch($sformatf("cce_total got %0d want %0d",
                            result.cce_total, want.cce_total));
                    end
                end
            end
            pending <= predicted_q.size();
        end
    end

endmodule

// ===== tb/tb_pdcch_ue_search_space_cce_start_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the search space core: drives requests and register writes, gives the verdict.
module tb_pdcch_ue_search_space_cce_start_core;
    import pdcch_ss_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES          = 12;
    localparam int FIXED_PHASES    = 4;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 600000;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [1:0] FIXED_BW [FIXED_PHASES]  = '{2'd0, 2'd3, 2'd0, 2'd3};
    localparam logic [1:0] FIXED_NG [FIXED_PHASES]  = '{2'd3, 2'd3, 2'd0, 2'd0};
    localparam logic       FIXED_EXT [FIXED_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    req_t                   request = '0;
    logic                   done;
    res_t                   result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     mismatches;
    int                     pending;
    int                     cycle_count = 0;
    bit                     no_idle = 1'b0;

    always #1 clk = ~clk;

    pdcch_ue_search_space_cce_start_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pdcch_cce_start_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int draw_gap();
        if ($urandom_range(0, 31) == 0)
        begin
            no_idle = !no_idle;
        end
        return no_idle ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic req_t make_req(input logic [15:0] ue, input logic [3:0] sf,
                                      input logic [1:0] agg, input logic [1:0] syms);
        req_t r;
        r.ue_identifier = ue;
        r.subframe_number = sf;
        r.aggregation_log2 = agg;
        r.control_symbols = syms;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        r.ue_identifier = 16'($urandom);
        case ($urandom_range(0, 7))
            0: r.ue_identifier = 16'h0000;
            1: r.ue_identifier = 16'hFFFF;
            default: ;
        endcase
        r.subframe_number = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                                        : 4'($urandom_range(0, 9));
        r.aggregation_log2 = 2'($urandom_range(0, 3));
        r.control_symbols = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        return r;
    endfunction

    task automatic drive_request(input req_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] bw, input logic [1:0] ng, input logic ext);
        write_register(CFG_BANDWIDTH, bw);
        write_register(CFG_PHICH, ng);
        write_register(CFG_EXT_CP, {1'($urandom), ext});
        write_register(CFG_SPARE, 2'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        req_t directed [$];
        directed.push_back(make_req(16'h0000, 4'd0, 2'd0, 2'd3));
        directed.push_back(make_req(16'hFFFF, 4'd15, 2'd3, 2'd3));
        directed.push_back(make_req(16'hFFFF, 4'd0, 2'd0, 2'd1));
        directed.push_back(make_req(16'h1234, 4'd9, 2'd0, 2'd3));
        directed.push_back(make_req(16'h1234, 4'd9, 2'd1, 2'd3));
        directed.push_back(make_req(16'h1234, 4'd9, 2'd2, 2'd3));
        directed.push_back(make_req(16'h1234, 4'd9, 2'd3, 2'd3));
        directed.push_back(make_req(16'hABCD, 4'd5, 2'd0, 2'd0));
        directed.push_back(make_req(16'h5555, 4'd1, 2'd1, 2'd1));
        directed.push_back(make_req(16'hAAAA, 4'd2, 2'd2, 2'd2));
        directed.push_back(make_req(16'h0001, 4'd15, 2'd0, 2'd2));
        directed.push_back(make_req(16'h8000, 4'd12, 2'd1, 2'd1));
        directed.push_back(make_req(16'h7FFF, 4'd10, 2'd3, 2'd0));
        directed.push_back(make_req(16'h0000, 4'd9, 2'd3, 2'd1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            drive_request(directed[i]);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            if (phase < FIXED_PHASES)
            begin
                configure(FIXED_BW[phase], FIXED_NG[phase], FIXED_EXT[phase]);
            end
            else
            begin
                configure(2'($urandom), 2'($urandom), 1'($urandom));
            end
            repeat (ITEMS_PER_PHASE) drive_request(random_request());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
